// File: src/nsdm_pkg.sv
// Package with the shared types and constants of the nonuniform-grid mixing core.
`default_nettype none
package nsdm_pkg;

	localparam int MAX_POINTS_DEFAULT = 1024;

	localparam int POS_W   = 17;
	localparam int CHI_W   = 32;
	localparam int IDX_W   = 10;
	localparam int TERM_W  = 48;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int DIFF_W  = POS_W + 1;
	localparam int SUM_W   = POS_W + 2;
	localparam int MULA_W  = 37;
	localparam int MULB_W  = 19;
	localparam int PROD_W  = MULA_W + MULB_W;
	localparam int NABS_W  = 36;
	localparam int DEN_W   = 52;
	localparam int DVD_W   = 84;
	localparam int QR_W    = DVD_W + 1;
	localparam int DIV_STEPS = DVD_W / 2;
	localparam int DCNT_W  = $clog2(DIV_STEPS);

	localparam logic [POS_W-1:0]  ONE_Q16   = POS_W'(65536);
	localparam logic [TERM_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [TERM_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_LEFT   = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_TAIL,
		ST_DIFF,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_MUL5,
		ST_MUL6,
		ST_PREP,
		ST_DIV,
		ST_ROUND
	} nsdm_state_t;

endpackage
`default_nettype wire

// File: src/nonuniform_second_derivative_mixing_core.sv
// Top level of the nonuniform-grid second-derivative mixing core.
// Grid points of a profile enter on the input channel (in_valid, in_stall); each
// word carries position, sample value, dissipation and a last-point flag. The
// term of a point leaves on the output channel (out_valid, out_stall) when its
// right neighbour has arrived, so results lag one point and the last point of a
// profile gives two words. The APB port writes enable and both boundary values.
// Each result runs through one shared 37x19 multiplier (ST_MUL1 to ST_MUL6)
// and one shared divider that retires two quotient bits a cycle (ST_PREP,
// ST_DIV), then ST_ROUND; an input point goes through ST_FIRST and ST_TAIL
// besides each result it causes. Zero spacing skips the arithmetic.
// The input is stalled while a point is being worked on; with enable low a word
// is taken and dropped. A finished word sits in the output register while the
// block takes the next point; the sequencer waits only if a second word is done
// before the first one leaves. Reset clears the sequencer and the output valid,
// empties the profile state and sets enable to one and both boundaries to zero.
`default_nettype none
module nonuniform_second_derivative_mixing_core #(
	parameter int MAX_POINTS = nsdm_pkg::MAX_POINTS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [nsdm_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [nsdm_pkg::DATA_W-1:0]  pwdata,
	output logic      [nsdm_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [nsdm_pkg::POS_W-1:0]   position,
	input  wire logic [nsdm_pkg::POS_W-1:0]   sample_value,
	input  wire logic [nsdm_pkg::CHI_W-1:0]   dissipation,
	input  wire logic                         last_point,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [nsdm_pkg::IDX_W-1:0]   point_index,
	output logic signed [nsdm_pkg::TERM_W-1:0] mixing_term,
	output logic                              saturated,
	output logic                              spacing_error,
	output logic                              last_result
);
	import nsdm_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS);
	localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	nsdm_state_t state_q, state_d;

	logic             enable_q;
	logic [POS_W-1:0] left_q, right_q;

	logic             in_last_q;
	logic [POS_W-1:0] in_pos_q, in_val_q;
	logic [CHI_W-1:0] in_chi_q;

	logic             holding_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] prev_pos_q, prev_val_q, held_pos_q, held_val_q;
	logic [CHI_W-1:0] held_chi_q;

	logic [POS_W-1:0] e_xm_q, e_ym_q, e_x_q, e_y_q, e_xp_q, e_yp_q;
	logic [CHI_W-1:0] e_chi_q;
	logic [CNT_W-1:0] e_idx_q;
	logic             e_last_q;

	logic signed [DIFF_W-1:0] dp_d, dm_d, dyp_d, dym_d;
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [DIFF_W-1:0] dp_q, dm_q, dyp_q, dym_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     err_q;

	logic signed [MULA_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic        [PROD_W-1:0] acc_q;
	logic signed [MULA_W-1:0] num_d;
	logic        [NABS_W-1:0] num_abs_q;
	logic                     num_neg_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] den_abs_d;
	logic        [DEN_W-1:0]  d_q;
	logic        [DVD_W-17:0] mag_d;

	logic [DVD_W-1:0]  dq_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DEN_W:0]    r2a, r2b;
	logic              gea, geb;
	logic [DEN_W-1:0]  ra;
	logic [DVD_W-1:0]  dq_next;
	logic [DEN_W-1:0]  rem_next;

	logic              rnd;
	logic [QR_W-1:0]   q_rnd;
	logic [TERM_W-1:0] limit;
	logic              sat_d;
	logic [TERM_W-1:0] mag48;
	logic [TERM_W-1:0] term_d;

	logic              cfg_wr;
	logic              in_acc;
	logic              out_load;
	logic [CNT_W-1:0]  cnt_inc;
	logic [EXT_W-1:0]  idx_ext;

	logic              out_valid_q;
	logic [CNT_W-1:0]  o_idx_q;
	logic [TERM_W-1:0] o_term_q;
	logic              o_sat_q, o_err_q, o_last_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			left_q   <= '0;
			right_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ENABLE: enable_q <= pwdata[0];
				REG_LEFT:   left_q   <= pwdata[POS_W-1:0];
				REG_RIGHT:  right_q  <= pwdata[POS_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE: prdata = DATA_W'(enable_q);
			REG_LEFT:   prdata = DATA_W'(left_q);
			REG_RIGHT:  prdata = DATA_W'(right_q);
			default:    prdata = '0;
		endcase
	end

	// Sequencer.
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_ROUND) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && enable_q) state_d = ST_FIRST;
			ST_FIRST: state_d = holding_q ? ST_DIFF : ST_TAIL;
			ST_TAIL:  state_d = in_last_q ? ST_DIFF : ST_IDLE;
			ST_DIFF:  state_d = (dp_d == '0 || dm_d == '0 || sum_d == '0) ? ST_ROUND : ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_MUL4;
			ST_MUL4:  state_d = ST_MUL5;
			ST_MUL5:  state_d = ST_MUL6;
			ST_MUL6:  state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (dcnt_q == '0) state_d = ST_ROUND;
			ST_ROUND: if (out_load) state_d = e_last_q ? ST_IDLE : ST_TAIL;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = MULA_W'(dyp_q);
				mul_b = MULB_W'(dm_q);
			end
			ST_MUL2: begin
				mul_a = MULA_W'(dym_q);
				mul_b = MULB_W'(dp_q);
			end
			ST_MUL3: begin
				mul_a = MULA_W'(dp_q);
				mul_b = MULB_W'(dm_q);
			end
			ST_MUL4: begin
				mul_a = $signed(prod_q[MULA_W-1:0]);
				mul_b = sum_q;
			end
			ST_MUL5: begin
				mul_a = $signed({1'b0, num_abs_q});
				mul_b = $signed({3'b000, e_chi_q[15:0]});
			end
			ST_MUL6: begin
				mul_a = $signed({1'b0, num_abs_q});
				mul_b = $signed({3'b000, e_chi_q[31:16]});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Profile state.
	assign cnt_inc = (cnt_q == CNT_W'(MAX_POINTS - 1)) ? '0 : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			cnt_q     <= '0;
		end else if (state_q == ST_FIRST) begin
			holding_q <= 1'b1;
			cnt_q     <= holding_q ? cnt_inc : '0;
		end else if (state_q == ST_TAIL && in_last_q) begin
			holding_q <= 1'b0;
			cnt_q     <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_pos_q  <= position;
			in_val_q  <= sample_value;
			in_chi_q  <= dissipation;
			in_last_q <= last_point;
		end
		if (state_q == ST_FIRST) begin
			held_pos_q <= in_pos_q;
			held_val_q <= in_val_q;
			held_chi_q <= in_chi_q;
			if (holding_q) begin
				e_xm_q     <= prev_pos_q;
				e_ym_q     <= prev_val_q;
				e_x_q      <= held_pos_q;
				e_y_q      <= held_val_q;
				e_chi_q    <= held_chi_q;
				e_xp_q     <= in_pos_q;
				e_yp_q     <= in_val_q;
				e_idx_q    <= cnt_q;
				e_last_q   <= 1'b0;
				prev_pos_q <= held_pos_q;
				prev_val_q <= held_val_q;
			end else begin
				prev_pos_q <= '0;
				prev_val_q <= left_q;
			end
		end
		if (state_q == ST_TAIL && in_last_q) begin
			e_xm_q   <= prev_pos_q;
			e_ym_q   <= prev_val_q;
			e_x_q    <= held_pos_q;
			e_y_q    <= held_val_q;
			e_chi_q  <= held_chi_q;
			e_xp_q   <= ONE_Q16;
			e_yp_q   <= right_q;
			e_idx_q  <= cnt_q;
			e_last_q <= 1'b1;
		end
	end

	// Spacings and the shared multiplier.
	assign dp_d  = $signed({1'b0, e_xp_q}) - $signed({1'b0, e_x_q});
	assign dm_d  = $signed({1'b0, e_x_q}) - $signed({1'b0, e_xm_q});
	assign dyp_d = $signed({1'b0, e_yp_q}) - $signed({1'b0, e_y_q});
	assign dym_d = $signed({1'b0, e_y_q}) - $signed({1'b0, e_ym_q});
	assign sum_d = $signed({dp_d[DIFF_W-1], dp_d}) + $signed({dm_d[DIFF_W-1], dm_d});

	assign num_d     = $signed(acc_q[MULA_W-1:0]) - $signed(prod_q[MULA_W-1:0]);
	assign den_abs_d = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign mag_d     = {prod_q[50:0], 16'h0000} + (DVD_W-16)'(acc_q[DEN_W-1:0]);

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			dp_q  <= dp_d;
			dm_q  <= dm_d;
			dyp_q <= dyp_d;
			dym_q <= dym_d;
			sum_q <= sum_d;
			err_q <= (dp_d == '0 || dm_d == '0 || sum_d == '0);
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MUL3 ||
				state_q == ST_MUL4 || state_q == ST_MUL5 || state_q == ST_MUL6) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL2 || state_q == ST_MUL6) begin
			acc_q <= prod_q;
		end
		if (state_q == ST_MUL3) begin
			num_neg_q <= num_d[MULA_W-1];
			num_abs_q <= num_d[MULA_W-1] ? NABS_W'(-num_d) : NABS_W'(num_d);
		end
		if (state_q == ST_MUL5) begin
			d_q   <= den_abs_d[DEN_W-1:0];
			neg_q <= num_neg_q ^ prod_q[PROD_W-1];
		end
	end

	// Divider, two restoring steps a cycle.
	always_comb begin
		r2a      = {rem_q, dq_q[DVD_W-1]};
		gea      = (r2a >= {1'b0, d_q});
		ra       = gea ? DEN_W'(r2a - {1'b0, d_q}) : r2a[DEN_W-1:0];
		r2b      = {ra, dq_q[DVD_W-2]};
		geb      = (r2b >= {1'b0, d_q});
		rem_next = geb ? DEN_W'(r2b - {1'b0, d_q}) : r2b[DEN_W-1:0];
		dq_next  = {dq_q[DVD_W-3:0], gea, geb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (state_q == ST_PREP) begin
			dcnt_q <= DCNT_W'(DIV_STEPS - 1);
		end else if (state_q == ST_DIV) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			dq_q  <= {mag_d, 16'h0000};
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dq_q  <= dq_next;
			rem_q <= rem_next;
		end
	end

	// Rounding, saturation and sign.
	always_comb begin
		rnd    = ({1'b0, rem_q} >= ({1'b0, d_q} - {1'b0, rem_q}));
		q_rnd  = {1'b0, dq_q} + QR_W'(rnd);
		limit  = neg_q ? NEG_LIMIT : POS_LIMIT;
		sat_d  = (q_rnd > QR_W'(limit));
		mag48  = sat_d ? limit : q_rnd[TERM_W-1:0];
		term_d = neg_q ? -mag48 : mag48;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_idx_q  <= e_idx_q;
			o_term_q <= err_q ? '0 : term_d;
			o_sat_q  <= err_q ? 1'b0 : sat_d;
			o_err_q  <= err_q;
			o_last_q <= e_last_q;
		end
	end

	assign idx_ext       = EXT_W'(o_idx_q);
	assign out_valid     = out_valid_q;
	assign point_index   = idx_ext[IDX_W-1:0];
	assign mixing_term   = $signed(o_term_q);
	assign saturated     = o_sat_q;
	assign spacing_error = o_err_q;
	assign last_result   = o_last_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spacing_error |-> mixing_term == '0 && !saturated)
		else $error("spacing error word carries a nonzero term");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			o_term_q == POS_LIMIT || o_term_q == NEG_LIMIT)
		else $error("saturated word is not at a limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && e_last_q |=> !holding_q && state_q == ST_IDLE)
		else $error("profile state still held after its last word");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && dcnt_q == '0 |=> state_q == ST_ROUND)
		else $error("divider did not finish on its last step");
`endif

endmodule
`default_nettype wire
